@@ src/otq_pkg.sv @@
// Shared types, sizes and helpers for the ordered timeout queue.
// No dependencies; the queue top, the slot cell and the bench import it.
package otq_pkg;

  localparam int MAX_TIMERS   = 16;
  localparam int TIME_BITS    = 32;
  localparam int HANDLE_COUNT = 16;
  localparam int HANDLE_BITS  = 4;
  localparam int RESULT_CAP   = 16;
  localparam int CAP_BITS     = $clog2(RESULT_CAP);

  typedef logic [TIME_BITS-1:0]   tmo_t;
  typedef logic [HANDLE_BITS-1:0] hnd_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EXPIRE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_LISTED     = 2'd1,
    STS_NOT_LISTED = 2'd2,
    STS_NONE_DUE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic occ;
    hnd_t hnd;
    tmo_t tmo;
  } cell_data_t;

  typedef struct packed {
    cell_op_e op;
    hnd_t     hnd;
    tmo_t     tmo;
  } cell_cmd_t;

  // Keep the low TIME_BITS bits of a 32-bit time value.
  function automatic tmo_t fit_time(logic [31:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[TIME_BITS-1:0];
  endfunction

  // Show the low 32 bits of a stored time value.
  function automatic logic [31:0] show_time(tmo_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

endpackage

@@ src/otq_in_if.sv @@
// Request channel of the ordered timeout queue: valid/ready plus one beat.
// Depends on nothing but fixed field widths.
interface otq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  handle;
  logic [31:0] timeout;
  logic [31:0] now_time;

  modport source(output valid, output opcode, output handle, output timeout,
                 output now_time, input ready);
  modport sink(input valid, input opcode, input handle, input timeout,
               input now_time, output ready);
endinterface

@@ src/otq_out_if.sv @@
// Result channel of the ordered timeout queue: valid/ready plus one beat.
// Depends on nothing but fixed field widths.
interface otq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  expired_handle;
  logic [31:0] expired_timeout;
  logic        last;

  modport source(output valid, output status, output expired_handle,
                 output expired_timeout, output last, input ready);
  modport sink(input valid, input status, input expired_handle,
               input expired_timeout, input last, output ready);
endinterface

@@ src/ordered_timeout_queue.sv @@
// Ordered timeout queue: top level with command sequencer, membership
// flags, result register and the row of otq_cell slots. Depends on otq_pkg,
// otq_in_if, otq_out_if and otq_cell.
//
// Usage:
//   req_i carries one command per beat: append, ordered insert, remove or
//   expire up to now_time. rsp_o carries results; every command gives one
//   beat with last set, except an expire that takes entries off the head,
//   which gives one beat per expired entry (at most 16) and marks the final
//   one with last.
//   The command beat is captured into the command registers; the result is
//   then worked out from them and loaded into the result register, which
//   drives rsp_o directly. The sequencer handles one command at a time:
//   req_i.ready is high only while it is idle. Each result step moves the
//   whole slot row at once (shift right to open a slot, shift left to close
//   one), so an expire is paced by the result register: one entry per
//   cycle while rsp_o is not stalled. A stalled receiver holds the result
//   register and freezes the sequencer and the slot row until the beat is
//   taken. Reset empties the list and clears all membership flags at once;
//   slot payloads carry no reset and are never read while unoccupied.
module ordered_timeout_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  otq_in_if.sink    req_i,
  otq_out_if.source rsp_o
);
  import otq_pkg::*;

  state_e                  state_q, state_d;
  opcode_e                 op_q;
  hnd_t                    hnd_q;
  tmo_t                    tmo_q;
  tmo_t                    now_q;
  logic [CAP_BITS-1:0]     cnt_q, cnt_d;
  logic [HANDLE_COUNT-1:0] listed_q, listed_d;

  logic                    rsp_valid_q;
  status_e                 status_q, status_d;
  hnd_t                    ehnd_q, ehnd_d;
  logic [31:0]             etmo_q, etmo_d;
  logic                    last_q, last_d;

  logic                    accept;
  logic                    slot_free;
  logic                    load_rsp;
  logic                    head_due;
  logic                    next_due;
  cell_cmd_t               cmd;

  cell_data_t              cells   [MAX_TIMERS];
  logic                    found   [MAX_TIMERS+1];

  // Accept a command only while idle.
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign slot_free   = !rsp_valid_q || rsp_o.ready;

  // Head entry and the one behind it, compared with the expire time.
  assign head_due = cells[0].occ && (cells[0].tmo <= now_q);
  assign next_due = cells[1].occ && (cells[1].tmo <= now_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    listed_d = listed_q;
    load_rsp = 1'b0;
    status_d = STS_OK;
    ehnd_d   = '0;
    etmo_d   = '0;
    last_d   = 1'b1;
    cmd      = '{op: CELL_HOLD, hnd: hnd_q, tmo: tmo_q};

    if (state_q == ST_IDLE) begin
      cnt_d = '0;
      if (accept) begin
        state_d = ST_EXEC;
      end
    end else if (slot_free) begin
      load_rsp = 1'b1;
      case (op_q)
        OP_APPEND, OP_INSERT: begin
          // Refuse a listed handle or a full row.
          if (listed_q[hnd_q] || cells[MAX_TIMERS-1].occ) begin
            status_d = STS_LISTED;
          end else begin
            cmd.op           = (op_q == OP_APPEND) ? CELL_APPEND : CELL_INSERT;
            listed_d[hnd_q]  = 1'b1;
          end
          state_d = ST_IDLE;
        end
        OP_REMOVE: begin
          if (!listed_q[hnd_q]) begin
            status_d = STS_NOT_LISTED;
          end else begin
            cmd.op          = CELL_REMOVE;
            listed_d[hnd_q] = 1'b0;
          end
          state_d = ST_IDLE;
        end
        default: begin
          // Expire: pop one due head entry per beat.
          if (head_due) begin
            cmd.op                  = CELL_POP;
            listed_d[cells[0].hnd]  = 1'b0;
            ehnd_d                  = cells[0].hnd;
            etmo_d                  = show_time(cells[0].tmo);
            last_d = !next_due || (cnt_q == CAP_BITS'(RESULT_CAP - 1));
            cnt_d  = cnt_q + 1'b1;
            if (last_d) begin
              state_d = ST_IDLE;
            end
          end else begin
            status_d = STS_NONE_DUE;
            state_d  = ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      listed_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      listed_q <= listed_d;
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Capture the command beat; hold the result beat until taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_e'(req_i.opcode);
      hnd_q <= req_i.handle;
      tmo_q <= fit_time(req_i.timeout);
      now_q <= fit_time(req_i.now_time);
    end
    if (load_rsp) begin
      status_q <= status_d;
      ehnd_q   <= ehnd_d;
      etmo_q   <= etmo_d;
      last_q   <= last_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.expired_handle  = ehnd_q;
  assign rsp_o.expired_timeout = etmo_q;
  assign rsp_o.last            = last_q;

  // Slot row: the found flag walks from head to tail to mark the first
  // slot that takes the new entry or loses its own.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
    cell_data_t left, right;

    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid_l
      assign left = cells[i-1];
    end

    if (i == MAX_TIMERS - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid_r
      assign right = cells[i+1];
    end

    otq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .found_i (found[i]),
      .left_i  (left),
      .right_i (right),
      .found_o (found[i+1]),
      .data_o  (cells[i])
    );
  end

endmodule

@@ src/otq_cell.sv @@
// One list slot of the queue: holds a handle and its timeout, shifts with
// its neighbors. Depends on otq_pkg.
module otq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otq_pkg::cell_cmd_t  cmd_i,
  input  logic                found_i,
  input  otq_pkg::cell_data_t left_i,
  input  otq_pkg::cell_data_t right_i,
  output logic                found_o,
  output otq_pkg::cell_data_t data_o
);
  import otq_pkg::*;

  logic       occ_q, occ_d;
  hnd_t       hnd_q, hnd_d;
  tmo_t       tmo_q, tmo_d;
  logic       hit;
  cell_data_t nxt;

  always_comb begin
    case (cmd_i.op)
      CELL_APPEND: hit = !occ_q;
      CELL_INSERT: hit = !occ_q || (tmo_q >= cmd_i.tmo);
      CELL_REMOVE: hit = occ_q && (hnd_q == cmd_i.hnd);
      default:     hit = 1'b0;
    endcase
  end

  assign found_o = found_i | hit;

  always_comb begin
    nxt = '{occ: occ_q, hnd: hnd_q, tmo: tmo_q};
    case (cmd_i.op)
      CELL_APPEND, CELL_INSERT: begin
        if (found_i) begin
          nxt = left_i;
        end else if (hit) begin
          nxt = '{occ: 1'b1, hnd: cmd_i.hnd, tmo: cmd_i.tmo};
        end
      end
      CELL_REMOVE: begin
        if (found_i || hit) begin
          nxt = right_i;
        end
      end
      CELL_POP: nxt = right_i;
      default: ;
    endcase
    occ_d = nxt.occ;
    hnd_d = nxt.hnd;
    tmo_d = nxt.tmo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hnd_q <= hnd_d;
    tmo_q <= tmo_d;
  end

  assign data_o = '{occ: occ_q, hnd: hnd_q, tmo: tmo_q};

endmodule

@@ tb/ordered_timeout_queue_test.sv @@
// Self-checking bench for ordered_timeout_queue: a directed table, then random
// timer traffic, checked beat by beat against an in-bench list model or table.
// Depends on otq_pkg, otq_in_if, otq_out_if and the ordered_timeout_queue RTL.
module ordered_timeout_queue_test;
  import otq_pkg::*;

  localparam int RAND_ITEMS = 110;
  localparam int CALM_ITEMS = 25;
  localparam int LIMIT      = 400000;

  typedef struct {
    opcode_e     op;
    hnd_t        hnd;
    logic [31:0] tmo;
    logic [31:0] now;
  } cmd_t;

  typedef struct {
    cmd_t    cmd;
    bit      typed;
    status_e sts;
  } row_t;

  typedef struct {
    status_e     status;
    hnd_t        hnd;
    logic [31:0] tmo;
    logic        last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  otq_in_if  req_if ();
  otq_out_if rsp_if ();

  ordered_timeout_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // List model: handles and timeouts in list order, head at index 0.
  hnd_t                    mdl_hnd [MAX_TIMERS];
  tmo_t                    mdl_tmo [MAX_TIMERS];
  int                      mdl_count = 0;
  bit [HANDLE_COUNT-1:0]   mdl_listed = '0;

  beat_t step_beats[$];       // beats the last command causes
  beat_t pending_results[$];  // beats still owed by the block
  row_t  dir_rows[$];

  int mismatch_count = 0;
  int beats_sent = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  function automatic void push_beat(status_e s, hnd_t h, logic [31:0] t, logic l);
    beat_t b;
    b.status = s;
    b.hnd    = h;
    b.tmo    = t;
    b.last   = l;
    step_beats.push_back(b);
  endfunction

  // Advance the list model by one command and collect the beats it gives.
  function automatic void apply_command(cmd_t c);
    tmo_t t;
    tmo_t now;
    int   pos;
    int   n;
    t   = tmo_t'(c.tmo);
    now = tmo_t'(c.now);
    step_beats.delete();
    case (c.op)
      OP_APPEND, OP_INSERT: begin
        if (mdl_listed[c.hnd] || mdl_count >= MAX_TIMERS) begin
          push_beat(STS_LISTED, '0, '0, 1'b1);
        end else begin
          pos = mdl_count;
          if (c.op == OP_INSERT) begin
            // Stop at the first entry whose timeout is not below the new one.
            pos = 0;
            while (pos < mdl_count && mdl_tmo[pos] < t) pos++;
          end
          for (int i = mdl_count; i > pos; i--) begin
            mdl_hnd[i] = mdl_hnd[i-1];
            mdl_tmo[i] = mdl_tmo[i-1];
          end
          mdl_hnd[pos] = c.hnd;
          mdl_tmo[pos] = t;
          mdl_count++;
          mdl_listed[c.hnd] = 1'b1;
          push_beat(STS_OK, '0, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (!mdl_listed[c.hnd]) begin
          push_beat(STS_NOT_LISTED, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < mdl_count && mdl_hnd[pos] != c.hnd) pos++;
          if (pos < mdl_count) begin
            for (int i = pos; i + 1 < mdl_count; i++) begin
              mdl_hnd[i] = mdl_hnd[i+1];
              mdl_tmo[i] = mdl_tmo[i+1];
            end
            mdl_count--;
          end
          mdl_listed[c.hnd] = 1'b0;
          push_beat(STS_OK, '0, '0, 1'b1);
        end
      end
      default: begin
        // Expire: take due entries off the head, at most one capped batch.
        n = 0;
        while (n < mdl_count && n < RESULT_CAP && mdl_tmo[n] <= now) n++;
        if (n == 0) begin
          push_beat(STS_NONE_DUE, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            mdl_listed[mdl_hnd[i]] = 1'b0;
            push_beat(STS_OK, mdl_hnd[i], 32'(mdl_tmo[i]), (i + 1 == n));
          end
          for (int i = n; i < mdl_count; i++) begin
            mdl_hnd[i-n] = mdl_hnd[i];
            mdl_tmo[i-n] = mdl_tmo[i];
          end
          mdl_count -= n;
        end
      end
    endcase
  endfunction

  function automatic void add_row(opcode_e op, hnd_t h, logic [31:0] t, logic [31:0] now,
                                  bit typed, status_e sts);
    row_t r;
    r.cmd.op  = op;
    r.cmd.hnd = h;
    r.cmd.tmo = t;
    r.cmd.now = now;
    r.typed   = typed;
    r.sts     = sts;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(63));
      3:       return 32'hFFFF_FFFF - 32'($urandom_range(63));
      default: return $urandom();
    endcase
  endfunction

  function automatic hnd_t pick_free();
    int start;
    start = $urandom_range(HANDLE_COUNT - 1);
    for (int i = 0; i < HANDLE_COUNT; i++) begin
      if (!mdl_listed[(start + i) % HANDLE_COUNT]) return hnd_t'((start + i) % HANDLE_COUNT);
    end
    return hnd_t'(start);
  endfunction

  function automatic hnd_t pick_listed();
    return mdl_hnd[$urandom_range(mdl_count - 1)];
  endfunction

  function automatic void flag_mismatch(string what, beat_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s) at cycle %0d:", what, cycle_count);
      $display("  expected sts=%0d hnd=%0d tmo=%h last=%0d",
               want.status, want.hnd, want.tmo, want.last);
      $display("  got      sts=%0d hnd=%0d tmo=%h last=%0d",
               rsp_if.status, rsp_if.expired_handle, rsp_if.expired_timeout, rsp_if.last);
    end
  endfunction

  // Present one command beat, hold it until accepted, then predict.
  // A random gap before the beat drops valid; back-to-back beats keep it high.
  task automatic drive_command(cmd_t c, bit typed, status_e sts);
    int    gap;
    beat_t b;
    if (!calm && $urandom_range(99) < 25) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid    <= 1'b1;
    req_if.opcode   <= c.op;
    req_if.handle   <= c.hnd;
    req_if.timeout  <= c.tmo;
    req_if.now_time <= c.now;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    beats_sent++;
    apply_command(c);
    if (typed) begin
      // Directed rows with an obvious answer carry it in the table.
      b.status = sts;
      b.hnd    = '0;
      b.tmo    = '0;
      b.last   = 1'b1;
      pending_results.push_back(b);
    end else begin
      foreach (step_beats[i]) pending_results.push_back(step_beats[i]);
    end
  endtask

  // Drop valid so the last beat is not taken again, then wait for all results.
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Load entries (mostly ordered inserts), then expire from the head.
  // With flush_all the list is filled up and emptied in one maximal burst.
  task automatic fill_list(int target, bit flush_all);
    cmd_t c;
    int   scale;
    scale = $urandom_range(3);
    for (int k = 0; k < target; k++) begin
      if (mdl_count >= MAX_TIMERS) break;
      c.op  = ($urandom_range(9) < 7) ? OP_INSERT : OP_APPEND;
      c.hnd = pick_free();
      if (!flush_all && mdl_count > 0 && $urandom_range(9) == 0) begin
        c.op  = OP_REMOVE;
        c.hnd = pick_listed();
      end
      case (scale)
        0:       c.tmo = 32'($urandom_range(15));
        1:       c.tmo = $urandom();
        2:       c.tmo = 32'hFFFF_FFFF - 32'($urandom_range(15));
        default: c.tmo = pick_time();
      endcase
      c.now = $urandom();
      drive_command(c, 1'b0, STS_OK);
    end
    c.op  = OP_EXPIRE;
    c.hnd = hnd_t'($urandom_range(15));
    c.tmo = $urandom();
    if (flush_all) begin
      c.now = 32'hFFFF_FFFF;
    end else begin
      case ($urandom_range(3))
        0:       c.now = (mdl_count > 0) ?
                         32'(mdl_tmo[$urandom_range(mdl_count - 1)]) : $urandom();
        1:       c.now = 32'h0000_0000;
        default: c.now = $urandom();
      endcase
    end
    drive_command(c, 1'b0, STS_OK);
  endtask

  // Result side: random stall bursts on ready, none in the calm tail.
  initial begin
    int hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        rsp_if.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(99) < 15) begin
        hold = $urandom_range(1, 18) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat with the oldest owed beat.
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        want.status = STS_OK;
        want.hnd    = '0;
        want.tmo    = '0;
        want.last   = 1'b0;
        flag_mismatch("unexpected beat", want);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status || rsp_if.expired_handle !== want.hnd ||
            rsp_if.expired_timeout !== want.tmo || rsp_if.last !== want.last) begin
          flag_mismatch("field", want);
        end
      end
    end
  end

  // Watchdog: end the run if it overstays the cycle budget.
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL ordered_timeout_queue");
    $finish;
  end

  initial begin
    cmd_t c;
    int   pick;
    bit   paused_mid;
    bit   full_done;
    paused_mid = 1'b0;
    full_done  = 1'b0;
    req_if.valid    = 1'b0;
    req_if.opcode   = OP_APPEND;
    req_if.handle   = '0;
    req_if.timeout  = '0;
    req_if.now_time = '0;

    // Directed table: empty list, duplicates, extremes, unsigned ordering.
    add_row(OP_EXPIRE, 4'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, STS_NONE_DUE);
    add_row(OP_REMOVE, 4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, STS_NOT_LISTED);
    add_row(OP_APPEND, 4'd0,  32'h0000_0000, 32'hA5A5_A5A5, 1'b1, STS_OK);
    add_row(OP_APPEND, 4'd15, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b1, STS_OK);
    add_row(OP_APPEND, 4'd0,  32'h0000_0005, 32'h0000_0000, 1'b1, STS_LISTED);
    add_row(OP_INSERT, 4'd1,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, STS_OK);
    add_row(OP_INSERT, 4'd2,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, STS_OK);
    add_row(OP_INSERT, 4'd15, 32'h0000_0003, 32'h0000_0000, 1'b1, STS_LISTED);
    add_row(OP_EXPIRE, 4'd9,  32'h1234_5678, 32'hFFFF_FFFE, 1'b0, STS_OK);
    add_row(OP_EXPIRE, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, STS_OK);
    add_row(OP_REMOVE, 4'd15, 32'hDEAD_BEEF, 32'h0000_0000, 1'b0, STS_OK);
    add_row(OP_REMOVE, 4'd15, 32'h0000_0000, 32'h0000_0000, 1'b1, STS_NOT_LISTED);
    add_row(OP_INSERT, 4'd7,  32'h8000_0000, 32'h0000_0000, 1'b0, STS_OK);
    add_row(OP_INSERT, 4'd8,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, STS_OK);
    add_row(OP_EXPIRE, 4'd15, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, STS_OK);
    add_row(OP_EXPIRE, 4'd0,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, STS_NONE_DUE);

    // Hold reset low, then release it on a falling edge.
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) drive_command(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].sts);

    // Stop sending until the block has paid out everything owed.
    drain_results();

    while (beats_sent < dir_rows.size() + RAND_ITEMS) begin
      if (beats_sent >= dir_rows.size() + RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!paused_mid && beats_sent >= dir_rows.size() + RAND_ITEMS / 2) begin
        drain_results();
        paused_mid = 1'b1;
      end
      pick = $urandom_range(9);
      if (!full_done || pick == 0) begin
        // Full list, every entry due: the longest expire burst.
        fill_list(MAX_TIMERS, 1'b1);
        full_done = 1'b1;
      end else if (pick < 7) begin
        fill_list($urandom_range(2, 8), 1'b0);
      end else begin
        // Noise: any opcode, mostly aimed at handles that make it do work.
        c.op  = opcode_e'($urandom_range(3));
        c.hnd = hnd_t'($urandom_range(15));
        c.tmo = pick_time();
        c.now = pick_time();
        if (c.op == OP_REMOVE && mdl_count > 0 && $urandom_range(9) < 7) c.hnd = pick_listed();
        if ((c.op == OP_APPEND || c.op == OP_INSERT) && mdl_count < MAX_TIMERS &&
            $urandom_range(9) < 6) c.hnd = pick_free();
        drive_command(c, 1'b0, STS_OK);
      end
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;

    drain_results();
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS ordered_timeout_queue");
    end else begin
      $display("FAIL ordered_timeout_queue");
    end
    $finish;
  end

endmodule
